// File: hdl/rational_arithmetic_unit_core_macros.svh
// Assertion macros used by the RTL controller.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");
// next-cycle implication
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/rau_pkg.sv
package rau_pkg;

    // datapath word and its split over the cell row
    localparam int DW      = 64;
    localparam int CELL_W  = 8;
    localparam int N_CELLS = DW / CELL_W;

    // operation codes
    localparam logic [2:0] F_ADD = 3'd0;
    localparam logic [2:0] F_SUB = 3'd1;
    localparam logic [2:0] F_MUL = 3'd2;
    localparam logic [2:0] F_DIV = 3'd3;
    localparam logic [2:0] F_GT  = 3'd4;
    localparam logic [2:0] F_EQ  = 3'd5;
    localparam logic [2:0] F_NEG = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        C_HOLD,
        C_LOAD,
        C_LOAD_XZ,
        C_SHR_X,
        C_SHR_Y,
        C_SHR_XY,
        C_SUB_X,
        C_SUB_Y,
        C_DIV
    } t_cell_op;

    // handed from a cell to the next higher cell
    typedef struct packed {
        logic x_msb;
        logic z_msb;
        logic bxy;
        logic byx;
    } t_up;

    // handed from a cell to the next lower cell
    typedef struct packed {
        logic x_lsb;
        logic y_lsb;
        logic dxy_lsb;
        logic dyx_lsb;
    } t_dn;

    typedef struct packed {
        t_cell_op        op;
        logic [DW-1:0]   ld_x;
        logic [DW-1:0]   ld_y;
        logic [DW-1:0]   ld_z;
    } t_chain_cmd;

    typedef struct packed {
        logic [DW-1:0]   x;
        logic [DW-1:0]   y;
        logic [DW-1:0]   z;
        logic            ge;
    } t_chain_sts;

endpackage

// File: hdl/rau_cell.sv
module rau_cell (
    input  logic                        i_clk,
    input  rau_pkg::t_cell_op           i_op,
    input  logic                        i_div,
    input  logic                        i_take,
    input  rau_pkg::t_up                i_up,
    output rau_pkg::t_up                o_up,
    input  rau_pkg::t_dn                i_dn,
    output rau_pkg::t_dn                o_dn,
    input  logic [rau_pkg::CELL_W-1:0]  i_ld_x,
    input  logic [rau_pkg::CELL_W-1:0]  i_ld_y,
    input  logic [rau_pkg::CELL_W-1:0]  i_ld_z,
    output logic [rau_pkg::CELL_W-1:0]  o_x,
    output logic [rau_pkg::CELL_W-1:0]  o_y,
    output logic [rau_pkg::CELL_W-1:0]  o_z
);
    import rau_pkg::*;

    logic [CELL_W-1:0] r_x, r_y, r_z;
    logic [CELL_W-1:0] n_x, n_y, n_z;
    logic [CELL_W-1:0] w_t, w_a, w_dxy, w_dyx;
    logic              w_bxy, w_byx;

    // remainder shifted left with the bit from below (divide step)
    assign w_t = {r_x[CELL_W-2:0], i_up.x_msb};
    assign w_a = i_div ? w_t : r_x;

    // slice subtractors, borrows ripple up the row
    assign {w_bxy, w_dxy} = {1'b0, w_a} - {1'b0, r_y} - {{CELL_W{1'b0}}, i_up.bxy};
    assign {w_byx, w_dyx} = {1'b0, r_y} - {1'b0, r_x} - {{CELL_W{1'b0}}, i_up.byx};

    assign o_up = '{x_msb: r_x[CELL_W-1], z_msb: r_z[CELL_W-1], bxy: w_bxy, byx: w_byx};
    assign o_dn = '{x_lsb: r_x[0], y_lsb: r_y[0], dxy_lsb: w_dxy[0], dyx_lsb: w_dyx[0]};

    // next slice values
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        case (i_op)
            C_LOAD: begin
                n_x = i_ld_x;
                n_y = i_ld_y;
                n_z = i_ld_z;
            end
            C_LOAD_XZ: begin
                n_x = i_ld_x;
                n_z = i_ld_z;
            end
            C_SHR_X:  n_x = {i_dn.x_lsb, r_x[CELL_W-1:1]};
            C_SHR_Y:  n_y = {i_dn.y_lsb, r_y[CELL_W-1:1]};
            C_SHR_XY: begin
                n_x = {i_dn.x_lsb, r_x[CELL_W-1:1]};
                n_y = {i_dn.y_lsb, r_y[CELL_W-1:1]};
            end
            C_SUB_X:  n_x = {i_dn.dxy_lsb, w_dxy[CELL_W-1:1]};
            C_SUB_Y:  n_y = {i_dn.dyx_lsb, w_dyx[CELL_W-1:1]};
            C_DIV: begin
                n_x = i_take ? w_dxy : w_t;
                n_z = {r_z[CELL_W-2:0], i_up.z_msb};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// File: hdl/rau_ctrl.sv
`include "rational_arithmetic_unit_core_macros.svh"

module rau_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_func,
    input  logic signed [31:0]   i_a_num,
    input  logic [30:0]          i_a_den,
    input  logic signed [31:0]   i_b_num,
    input  logic [30:0]          i_b_den,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_res_num,
    output logic [30:0]          o_res_den,
    output logic                 o_flag,
    output logic [1:0]           o_status,
    output rau_pkg::t_chain_cmd  o_cmd,
    output logic                 o_div,
    input  rau_pkg::t_chain_sts  i_sts
);
    import rau_pkg::*;

    localparam logic [DW-1:0] MAXPOS = (DW'(1) << (WORD_BITS - 1)) - DW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_CHK, S_TWOS, S_GCD,
        S_DIVN, S_LDD, S_DIVD, S_FIN, S_DONE
    } t_state;

    t_state                r_state;
    logic [5:0]            r_cnt;
    logic [2:0]            r_func;
    logic signed [31:0]    r_an, r_bn;
    logic [30:0]           r_ad, r_bd;
    logic signed [63:0]    r_l, r_r, r_nn, r_dd, r_db;
    logic signed [63:0]    r_n, r_d;
    logic                  r_neg;
    logic [DW-1:0]         r_nm, r_dm, r_qn;
    logic signed [31:0]    r_rn;
    logic [30:0]           r_rd;
    logic                  r_rf;
    logic [1:0]            r_rs;
    logic                  r_ov;

    logic signed [31:0]    w_ma, w_mb;
    logic signed [63:0]    w_prod, w_n, w_d;
    logic [DW-1:0]         w_nm, w_dm, w_qd;
    logic                  w_flag, w_out_free;
    logic [32:0]           w_cl_z, w_cl_f;

    // clamp sign and magnitude to the signed word range: {saturated, value}
    function automatic logic [32:0] f_clamp(input logic neg, input logic [DW-1:0] mag);
        logic [DW-1:0] m;
        logic          s;
        m = mag;
        s = 1'b0;
        if (neg) begin
            if (mag > MAXPOS + DW'(1)) begin
                m = MAXPOS + DW'(1);
                s = 1'b1;
            end
            m = DW'(0) - m;
        end else if (mag > MAXPOS) begin
            m = MAXPOS;
            s = 1'b1;
        end
        return {s, m[31:0]};
    endfunction

    // shared multiplier, one product per cycle
    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin w_ma = r_an;           w_mb = $signed({1'b0, r_bd}); end
            3'd1: begin w_ma = r_bn;           w_mb = $signed({1'b0, r_ad}); end
            3'd2: begin w_ma = r_an;           w_mb = r_bn;                   end
            3'd3: begin w_ma = $signed({1'b0, r_ad}); w_mb = $signed({1'b0, r_bd}); end
            default: begin w_ma = $signed({1'b0, r_ad}); w_mb = r_bn; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // unreduced numerator and denominator
    always_comb begin
        case (r_func)
            F_ADD:   begin w_n = r_l + r_r; w_d = r_dd; end
            F_SUB:   begin w_n = r_l - r_r; w_d = r_dd; end
            F_MUL:   begin w_n = r_nn;      w_d = r_dd; end
            F_DIV:   begin w_n = r_l;       w_d = r_db; end
            F_NEG:   begin
                w_n = -$signed({{32{r_an[31]}}, r_an});
                w_d = $signed({33'd0, r_ad});
            end
            default: begin w_n = 64'sd0;    w_d = 64'sd1; end
        endcase
    end

    assign w_flag = (r_func == F_GT) ? (r_l > r_r) : (r_l == r_r);
    assign w_nm   = r_n[63] ? DW'(64'd0 - r_n) : DW'(r_n);
    assign w_dm   = r_d[63] ? DW'(64'd0 - r_d) : DW'(r_d);
    assign w_cl_z = f_clamp(r_n[63], w_nm);
    assign w_cl_f = f_clamp(r_neg, r_qn);
    assign w_qd   = i_sts.z;
    assign w_out_free = !r_ov || !i_stall;

    // divide mode of the row, decoded from state alone
    assign o_div = (r_state == S_DIVN) || (r_state == S_DIVD);

    // commands to the cell row
    always_comb begin
        o_cmd.op   = C_HOLD;
        o_cmd.ld_x = w_nm;
        o_cmd.ld_y = w_dm;
        o_cmd.ld_z = '0;
        unique case (r_state)
            S_CHK: begin
                if (w_dm != '0 && w_nm != '0) o_cmd.op = C_LOAD;
            end
            S_TWOS: begin
                if (!i_sts.x[0] && !i_sts.y[0]) o_cmd.op = C_SHR_XY;
            end
            S_GCD: begin
                if (i_sts.x == '0) begin
                    o_cmd.op   = C_LOAD_XZ;
                    o_cmd.ld_x = '0;
                    o_cmd.ld_z = r_nm;
                end else if (!i_sts.x[0]) begin
                    o_cmd.op = C_SHR_X;
                end else if (!i_sts.y[0]) begin
                    o_cmd.op = C_SHR_Y;
                end else if (i_sts.ge) begin
                    o_cmd.op = C_SUB_X;
                end else begin
                    o_cmd.op = C_SUB_Y;
                end
            end
            S_DIVN, S_DIVD: o_cmd.op = C_DIV;
            S_LDD: begin
                o_cmd.op   = C_LOAD_XZ;
                o_cmd.ld_x = '0;
                o_cmd.ld_z = r_dm;
            end
            default: ;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (r_state == S_DONE && w_out_free) r_ov <= 1'b1;
            else if (!i_stall)                   r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_an    <= i_a_num;
                        r_ad    <= i_a_den;
                        r_bn    <= i_b_num;
                        r_bd    <= i_b_den;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_cnt[2:0])
                        3'd0:    r_l  <= w_prod;
                        3'd1:    r_r  <= w_prod;
                        3'd2:    r_nn <= w_prod;
                        3'd3:    r_dd <= w_prod;
                        default: r_db <= w_prod;
                    endcase
                    if (r_cnt == 6'd4) begin
                        r_cnt   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SUM: begin
                    if (r_func == F_GT || r_func == F_EQ) begin
                        r_rn    <= {31'd0, w_flag};
                        r_rd    <= 31'd1;
                        r_rf    <= w_flag;
                        r_rs    <= ST_OK;
                        r_state <= S_DONE;
                    end else if (r_func == F_ADD || r_func == F_SUB || r_func == F_MUL
                                 || r_func == F_DIV || r_func == F_NEG) begin
                        r_n     <= w_n;
                        r_d     <= w_d;
                        r_state <= S_CHK;
                    end else begin
                        r_rn    <= '0;
                        r_rd    <= 31'd1;
                        r_rf    <= 1'b0;
                        r_rs    <= ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_CHK: begin
                    r_rf <= 1'b0;
                    r_rd <= 31'd1;
                    if (w_dm == '0) begin
                        r_rn    <= w_cl_z[31:0];
                        r_rs    <= ST_ZDEN;
                        r_state <= S_DONE;
                    end else if (w_nm == '0) begin
                        r_rn    <= '0;
                        r_rs    <= ST_OK;
                        r_state <= S_DONE;
                    end else begin
                        r_neg   <= r_n[63] ^ r_d[63];
                        r_state <= S_TWOS;
                    end
                end
                S_TWOS: begin
                    if (i_sts.x[0] || i_sts.y[0]) begin
                        r_nm    <= i_sts.x;
                        r_dm    <= i_sts.y;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (i_sts.x == '0) begin
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) r_state <= S_LDD;
                end
                S_LDD: begin
                    r_qn    <= i_sts.z;
                    r_state <= S_DIVD;
                end
                S_DIVD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_rn <= w_cl_f[31:0];
                    if (w_qd > MAXPOS) begin
                        r_rd <= MAXPOS[30:0];
                        r_rs <= ST_OVF;
                    end else begin
                        r_rd <= w_qd[30:0];
                        r_rs <= w_cl_f[32] ? ST_OVF : ST_OK;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_res_num <= r_rn;
                        o_res_den <= r_rd;
                        o_flag    <= r_rf;
                        o_status  <= r_rs;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;

    // gcd loop never sees a zero right word
    `RAU_ASSERT_IMP(a_gcd_y_nz, i_clk, i_rst_n, r_state == S_GCD, i_sts.y != '0)
    // both divisions by the gcd are exact
    `RAU_ASSERT_IMP(a_num_exact, i_clk, i_rst_n, r_state == S_LDD, i_sts.x == '0)
    `RAU_ASSERT_IMP(a_den_exact, i_clk, i_rst_n, r_state == S_FIN, i_sts.x == '0)
    // a finished beat is presented right after leaving the done state
    `RAU_ASSERT_NXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && w_out_free, r_ov)

endmodule

// File: hdl/rational_arithmetic_unit_core.sv
// Channel | Handshake         | Beat payload
// in      | i_valid / o_stall | i_func, i_a_num, i_a_den, i_b_num, i_b_den
// out     | o_valid / i_stall | o_res_num, o_res_den, o_flag, o_status
//
// One item at a time. Compare ops and the unused code finish after the products, a zero
// numerator or zero denominator after the check; reducing ops go on through the
// common-twos shift and the gcd loop (one cell-row step per cycle), then two divides.
// Cost is set by the binary gcd and two 64-step restoring divides in the row.
// Reset is synchronous, active low; it clears the sequencer and output valid.
// The next beat is taken while a finished result waits under i_stall; a second
// finished result holds in the done state, with o_stall high, until then.
module rational_arithmetic_unit_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_func,
    input  logic signed [31:0]  i_a_num,
    input  logic [30:0]         i_a_den,
    input  logic signed [31:0]  i_b_num,
    input  logic [30:0]         i_b_den,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_res_num,
    output logic [30:0]         o_res_den,
    output logic                o_flag,
    output logic [1:0]          o_status
);
    import rau_pkg::*;

    t_chain_cmd    w_cmd;
    t_chain_sts    w_sts;
    t_up           w_up [N_CELLS];
    t_dn           w_dn [N_CELLS];
    t_up           w_up0;
    logic [DW-1:0] w_x, w_y, w_z;
    logic          w_take;
    logic          w_div;

    // quotient bit / compare result from the top borrow
    assign w_take = ~w_up[N_CELLS-1].bxy;
    assign w_up0  = '{x_msb: w_z[DW-1], z_msb: w_take, bxy: 1'b0, byx: 1'b0};
    assign w_sts  = '{x: w_x, y: w_y, z: w_z, ge: w_take};

    rau_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_flag    (o_flag),
        .o_status  (o_status),
        .o_cmd     (w_cmd),
        .o_div     (w_div),
        .i_sts     (w_sts)
    );

    // row of bit-slice cells, lowest slice first
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        t_up w_in_up;
        t_dn w_in_dn;
        if (g == 0) begin : g_lo
            assign w_in_up = w_up0;
        end else begin : g_mid
            assign w_in_up = w_up[g-1];
        end
        if (g == N_CELLS - 1) begin : g_hi
            assign w_in_dn = '0;
        end else begin : g_nhi
            assign w_in_dn = w_dn[g+1];
        end
        rau_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_cmd.op),
            .i_div  (w_div),
            .i_take (w_take),
            .i_up   (w_in_up),
            .o_up   (w_up[g]),
            .i_dn   (w_in_dn),
            .o_dn   (w_dn[g]),
            .i_ld_x (w_cmd.ld_x[g*CELL_W +: CELL_W]),
            .i_ld_y (w_cmd.ld_y[g*CELL_W +: CELL_W]),
            .i_ld_z (w_cmd.ld_z[g*CELL_W +: CELL_W]),
            .o_x    (w_x[g*CELL_W +: CELL_W]),
            .o_y    (w_y[g*CELL_W +: CELL_W]),
            .o_z    (w_z[g*CELL_W +: CELL_W])
        );
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

import rau_pkg::*;

typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               flag;
    logic [1:0]         status;
} frac_res_t;

// Predicts each fraction result and checks the block's output beats in order
class frac_scoreboard;
    frac_res_t pending[$];
    int        n_err;
    int        n_checked;

    function logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Clamp sign/magnitude numerator to 32 bits; returns 1 if clamped
    function bit clamp_num(bit neg, logic [63:0] mag, output logic signed [31:0] q);
        bit sat;
        sat = 0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin mag = 64'h8000_0000; sat = 1; end
            q = 32'(64'd0 - mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) begin mag = 64'h7FFF_FFFF; sat = 1; end
            q = mag[31:0];
        end
        return sat;
    endfunction

    function frac_res_t reduce(logic signed [63:0] n, logic signed [63:0] d);
        frac_res_t r;
        logic [63:0] nm, dm, g;
        bit neg, sat;
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        neg = (n < 0) != (d < 0);
        r.flag = 0;
        if (dm == 0) begin
            void'(clamp_num(n < 0, nm, r.num));
            r.den = 1;
            r.status = ST_ZDEN;
            return r;
        end
        if (nm == 0) begin
            r.num = 0; r.den = 1; r.status = ST_OK;
            return r;
        end
        g = gcd_u64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        sat = clamp_num(neg, nm, r.num);
        if (dm > 64'h7FFF_FFFF) begin dm = 64'h7FFF_FFFF; sat = 1; end
        r.den = dm[30:0];
        r.status = sat ? ST_OVF : ST_OK;
        return r;
    endfunction

    function void note_operands(logic [2:0] fn, logic signed [31:0] an, logic [30:0] ad,
                                logic signed [31:0] bn, logic [30:0] bd);
        logic signed [63:0] san, sad, sbn, sbd, lx, rx;
        frac_res_t r;
        bit f;
        san = an; sbn = bn;
        sad = {33'd0, ad}; sbd = {33'd0, bd};
        lx = san * sbd;
        rx = sbn * sad;
        r.num = 0; r.den = 1; r.flag = 0; r.status = ST_OK;
        case (fn)
            F_ADD: r = reduce(lx + rx, sad * sbd);
            F_SUB: r = reduce(lx - rx, sad * sbd);
            F_MUL: r = reduce(san * sbn, sad * sbd);
            F_DIV: r = reduce(lx, sad * sbn);
            F_GT, F_EQ: begin
                f = (fn == F_GT) ? (lx > rx) : (lx == rx);
                r.num = f; r.flag = f;
            end
            F_NEG: r = reduce(-san, sad);
            default: ;
        endcase
        pending.insert(pending.size(), r);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        n_err++;
    endtask

    task check_beat(logic signed [31:0] num, logic [30:0] den, logic flag, logic [1:0] st);
        frac_res_t e;
        if (pending.size() == 0) begin
            report("result beat with nothing outstanding");
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (num !== e.num) report($sformatf("num %0d exp %0d", num, e.num));
        if (den !== e.den) report($sformatf("den %0d exp %0d", den, e.den));
        if (flag !== e.flag) report($sformatf("flag %0b exp %0b", flag, e.flag));
        if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
    endtask
endclass

module testbench;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_func;
    logic signed [31:0] i_a_num;
    logic [30:0]        i_a_den;
    logic signed [31:0] i_b_num;
    logic [30:0]        i_b_den;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic               o_flag;
    logic [1:0]         o_status;

    frac_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  n_sent;

    rational_arithmetic_unit_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stall, or a long hold when requested
    initial begin
        i_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_recv) i_stall <= 1'b1;
            else i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_beat(o_res_num, o_res_den, o_flag, o_status);
    end

    // Offer one beat, hold it until accepted; valid drops only in idle cycles
    task send_beat(logic [2:0] fn, logic signed [31:0] an, logic [30:0] ad,
                   logic signed [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn; i_a_num <= an; i_a_den <= ad; i_b_num <= bn; i_b_den <= bd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_operands(fn, an, ad, bn, bd);
        n_sent++;
        @(negedge i_clk);
    endtask

    function logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'($urandom_range(20)) - 32'd10;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            3: return 32'($urandom_range(1000));
            default: return $urandom;
        endcase
    endfunction

    function logic [30:0] rand_den();
        case ($urandom_range(5))
            0: return 31'($urandom_range(12));
            1: return 31'(31'h7FFF_FFFF - $urandom_range(3));
            2: return 31'($urandom_range(1000)) + 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    task random_phase(int n);
        for (int k = 0; k < n; k++)
            send_beat(3'($urandom_range(7)), rand_word(), rand_den(), rand_word(), rand_den());
    endtask

    // stop offering and wait for every outstanding result
    task drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        hold_recv = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_func = '0; i_a_num = '0; i_a_den = 31'd1; i_b_num = '0; i_b_den = 31'd1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every op, field extremes, zero numerator and denominator, overflow
        send_beat(F_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_beat(F_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
        send_beat(F_MUL, -32'sd6, 31'd4, 32'sd2, 31'd3);
        send_beat(F_DIV, 32'sd3, 31'd5, 32'sd0, 31'd7);
        send_beat(F_DIV, -32'sd3, 31'd5, 32'sd2, 31'd7);
        send_beat(F_GT, 32'sd1, 31'd3, 32'sd1, 31'd4);
        send_beat(F_GT, -32'sd1, 31'd3, 32'sd1, 31'd4);
        send_beat(F_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2);
        send_beat(F_EQ, 32'sd2, 31'd4, 32'sd1, 31'd3);
        send_beat(F_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd1);
        send_beat(F_NEG, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0, 31'd1);
        send_beat(3'd7, 32'sd5, 31'd5, 32'sd5, 31'd5);
        send_beat(F_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_beat(F_SUB, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_beat(F_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        send_beat(F_MUL, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'h7FFF_FFFE);
        send_beat(F_ADD, 32'sd1, 31'd0, 32'sd1, 31'd5);
        send_beat(F_DIV, 32'h8000_0000, 31'd1, 32'sd0, 31'd1);
        send_beat(F_GT, 32'sd0, 31'd0, 32'sd0, 31'd0);
        send_beat(F_ADD, 32'sd0, 31'h7FFF_FFFF, 32'sd0, 31'h5555_5555);
        send_beat(F_DIV, 32'h7FFF_FFFF, 31'h2AAA_AAAA, -32'sd1, 31'h5555_5555);
        drain();

        // pressure: receiver holds off while sender keeps offering
        fork
            begin
                random_phase(4);
                i_valid <= 1'b0;
            end
            begin
                hold_recv = 1;
                repeat (2000) @(posedge i_clk);
                hold_recv = 0;
            end
        join
        drain();

        send_idle_pct = 19; recv_idle_pct = 50;
        random_phase(230);
        send_idle_pct = 50; recv_idle_pct = 19;
        random_phase(230);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(230);

        drain();
        repeat (400) @(posedge i_clk);
        $display("covered %0d operand beats, %0d results checked, all ops and edge values",
                 n_sent, sb.n_checked);
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
